// ===== src/lbl_pkg.sv =====
// Shared types, constants and the exp2 root table for the brightness mapper.
// Used by lbl_mul, lbl_core and log_brightness_to_luminance.
package lbl_pkg;

	localparam int LEVEL_W    = 10;
	localparam int LUM_W      = 24;
	localparam int FRAC_W     = 30;
	localparam int LOG_W      = 35;
	localparam int WIDE_W     = 45;
	localparam int MUL_W      = 32;
	localparam int DEF_FULL_SCALE = 100;
	localparam int DEF_LUM_WIDTH  = 24;

	localparam logic [LUM_W-1:0] MIN_LUM_RESET = 24'd5000;
	localparam logic [LUM_W-1:0] MAX_LUM_RESET = 24'd500000;

	// register indexes
	localparam logic REG_MIN_LUM = 1'b0;
	localparam logic REG_MAX_LUM = 1'b1;

	typedef struct packed {
		logic [LUM_W-1:0] lo;
		logic [LUM_W-1:0] hi;
	} lbl_cfg_t;

	typedef struct packed {
		logic done;
		logic idle;
	} lbl_stat_t;

	typedef logic [FRAC_W-1:0][MUL_W-1:0] root_tab_t;

	// Chain of square roots 2^(2^-i) in Q1.31, i = 1..30, each the truncated
	// integer root of the previous one shifted up by 31. Evaluated at elaboration.
	function automatic root_tab_t build_roots();
		logic [63:0] c;
		logic [63:0] x;
		logic [63:0] res;
		logic [63:0] bit_v;
		root_tab_t   t;
		c = 64'd1 << 32;
		for (int i = 0; i < FRAC_W; i++) begin
			x     = c << 31;
			res   = 64'd0;
			bit_v = 64'd1 << 62;
			for (int j = 0; j < 32; j++) begin
				if (x >= res + bit_v) begin
					x   = x - (res + bit_v);
					res = (res >> 1) + bit_v;
				end else begin
					res = res >> 1;
				end
				bit_v = bit_v >> 2;
			end
			c    = res;
			t[i] = res[MUL_W-1:0];
		end
		return t;
	endfunction

	localparam root_tab_t ROOTS = build_roots();

endpackage

// ===== src/lbl_mul.sv =====
// Shared 32x32 multiplier with a registered product.
// Depends on lbl_pkg for operand widths.
module lbl_mul (
	input  logic                          clk,
	input  logic                          en,
	input  logic [lbl_pkg::MUL_W-1:0]     a,
	input  logic [lbl_pkg::MUL_W-1:0]     b,
	output logic [2*lbl_pkg::MUL_W-1:0]   prod_q
);

	// capture product when issued
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

endmodule

// ===== src/lbl_core.sv =====
// Sequencer for the log/exp luminance curve: serial normalize, log2 by squaring,
// shift-add multiply, bit-serial divide, exp2 by root products, serial shift.
// Depends on lbl_pkg and lbl_mul.
module lbl_core #(
	parameter int FULL_SCALE = lbl_pkg::DEF_FULL_SCALE,
	parameter int LUM_WIDTH  = lbl_pkg::DEF_LUM_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lbl_pkg::LEVEL_W-1:0]   level,
	input  lbl_pkg::lbl_cfg_t             cfg,
	input  logic                          take,
	output logic [lbl_pkg::LUM_W-1:0]     result,
	output lbl_pkg::lbl_stat_t            stat
);

	localparam int LW = lbl_pkg::LEVEL_W;
	localparam int NW = lbl_pkg::LUM_W;
	localparam int FW = lbl_pkg::FRAC_W;
	localparam int GW = lbl_pkg::LOG_W;
	localparam int WW = lbl_pkg::WIDE_W;
	localparam int MW = lbl_pkg::MUL_W;
	localparam logic [LW-1:0] FS = LW'(FULL_SCALE);
	localparam logic [32:0]   SAT = 33'((64'd1 << LUM_WIDTH) - 64'd1);

	typedef enum logic [12:0] {
		ST_IDLE  = 13'b0000000000001,
		ST_NORM  = 13'b0000000000010,
		ST_LSQ   = 13'b0000000000100,
		ST_LUSE  = 13'b0000000001000,
		ST_MACC  = 13'b0000000010000,
		ST_DIV   = 13'b0000000100000,
		ST_EXP   = 13'b0000001000000,
		ST_EUSE  = 13'b0000010000000,
		ST_SCALE = 13'b0000100000000,
		ST_SUSE  = 13'b0001000000000,
		ST_SHR   = 13'b0010000000000,
		ST_CLAMP = 13'b0100000000000,
		ST_DONE  = 13'b1000000000000
	} state_t;

	state_t          state_q;
	logic [NW-1:0]   lo_q, hi_q, res_q;
	logic [LW-1:0]   lvl_q;
	logic [MW-1:0]   x_q, m_q, exp_q;
	logic [4:0]      k_q, n_q, sh_q;
	logic [FW-1:0]   frac_q, tsh_q;
	logic [GW-1:0]   loghi_q, diff_q;
	logic [WW-1:0]   wide_q;
	logic [LW-1:0]   rem_q;
	logic [5:0]      cnt_q;
	logic            which_q;
	logic [55:0]     p_q;

	logic            mul_en;
	logic [MW-1:0]   mul_a, mul_b;
	logic [2*MW-1:0] prod_q;

	logic [32:0]     sq;
	logic [FW-1:0]   frac_new;
	logic [LW:0]     div_r;
	logic            div_ge;
	logic [WW-1:0]   quo_next;

	lbl_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// select multiplier operands by step
	always_comb begin
		mul_en = 1'b0;
		mul_a  = m_q;
		mul_b  = m_q;
		unique case (state_q)
			ST_LSQ: begin
				mul_en = 1'b1;
			end
			ST_EXP: begin
				mul_en = tsh_q[FW-1];
				mul_a  = exp_q;
				mul_b  = lbl_pkg::ROOTS[cnt_q[4:0]];
			end
			ST_SCALE: begin
				mul_en = 1'b1;
				mul_a  = {{(MW-NW){1'b0}}, lo_q};
				mul_b  = exp_q;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// log and divide step values
	assign sq       = prod_q[63:31];
	assign frac_new = {frac_q[FW-2:0], sq[32]};
	assign div_r    = {rem_q, wide_q[WW-1]};
	assign div_ge   = (div_r >= {1'b0, FS});
	assign quo_next = {wide_q[WW-2:0], div_ge};

	// saturate the finished value
	assign result = ({9'd0, res_q} > SAT) ? SAT[NW-1:0] : res_q;
	assign stat.done = (state_q == ST_DONE);
	assign stat.idle = (state_q == ST_IDLE);

	// advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						lo_q    <= cfg.lo;
						hi_q    <= cfg.hi;
						lvl_q   <= level;
						x_q     <= {{(MW-NW){1'b0}}, cfg.hi};
						k_q     <= 5'd31;
						which_q <= 1'b0;
						cnt_q   <= '0;
						if (level == '0) begin
							res_q   <= cfg.lo;
							state_q <= ST_DONE;
						end else if (level >= FS) begin
							res_q   <= cfg.hi;
							state_q <= ST_DONE;
						end else if (cfg.lo == '0) begin
							res_q   <= '0;
							state_q <= ST_DONE;
						end else if (cfg.hi <= cfg.lo) begin
							res_q   <= cfg.hi;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_NORM;
						end
					end
				end
				ST_NORM: begin
					if (x_q[MW-1]) begin
						m_q     <= x_q;
						cnt_q   <= '0;
						state_q <= ST_LSQ;
					end else begin
						x_q <= {x_q[MW-2:0], 1'b0};
						k_q <= k_q - 5'd1;
					end
				end
				ST_LSQ: begin
					state_q <= ST_LUSE;
				end
				ST_LUSE: begin
					frac_q <= frac_new;
					m_q    <= sq[32] ? sq[32:1] : sq[31:0];
					if (cnt_q == 6'(FW - 1)) begin
						if (!which_q) begin
							loghi_q <= {k_q, frac_new};
							x_q     <= {{(MW-NW){1'b0}}, lo_q};
							k_q     <= 5'd31;
							which_q <= 1'b1;
							state_q <= ST_NORM;
						end else begin
							diff_q  <= loghi_q - {k_q, frac_new};
							wide_q  <= '0;
							cnt_q   <= '0;
							state_q <= ST_MACC;
						end
					end else begin
						cnt_q   <= cnt_q + 6'd1;
						state_q <= ST_LSQ;
					end
				end
				ST_MACC: begin
					wide_q <= {wide_q[WW-2:0], 1'b0}
						+ (lvl_q[LW-1] ? {{(WW-GW){1'b0}}, diff_q} : '0);
					lvl_q  <= {lvl_q[LW-2:0], 1'b0};
					if (cnt_q == 6'(LW - 1)) begin
						cnt_q   <= '0;
						rem_q   <= '0;
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_DIV: begin
					rem_q  <= div_ge ? LW'(div_r - {1'b0, FS}) : div_r[LW-1:0];
					wide_q <= quo_next;
					if (cnt_q == 6'(WW - 1)) begin
						tsh_q <= quo_next[FW-1:0];
						n_q   <= quo_next[GW-1:FW];
						exp_q <= {1'b1, {(MW-1){1'b0}}};
						cnt_q <= '0;
						if (|quo_next[WW-1:GW]) begin
							res_q   <= hi_q;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_EXP;
						end
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_EXP: begin
					if (tsh_q[FW-1]) begin
						state_q <= ST_EUSE;
					end else begin
						tsh_q <= {tsh_q[FW-2:0], 1'b0};
						cnt_q <= cnt_q + 6'd1;
						if (cnt_q == 6'(FW - 1)) begin
							state_q <= ST_SCALE;
						end
					end
				end
				ST_EUSE: begin
					exp_q <= prod_q[62:31];
					tsh_q <= {tsh_q[FW-2:0], 1'b0};
					cnt_q <= cnt_q + 6'd1;
					state_q <= (cnt_q == 6'(FW - 1)) ? ST_SCALE : ST_EXP;
				end
				ST_SCALE: begin
					state_q <= ST_SUSE;
				end
				ST_SUSE: begin
					p_q     <= prod_q[55:0];
					sh_q    <= 5'd31 - n_q;
					state_q <= ST_SHR;
				end
				ST_SHR: begin
					if (sh_q == '0) begin
						state_q <= ST_CLAMP;
					end else begin
						p_q  <= {1'b0, p_q[55:1]};
						sh_q <= sh_q - 5'd1;
					end
				end
				ST_CLAMP: begin
					if (p_q < {32'd0, lo_q}) begin
						res_q <= lo_q;
					end else if (p_q > {32'd0, hi_q}) begin
						res_q <= hi_q;
					end else begin
						res_q <= p_q[NW-1:0];
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/log_brightness_to_luminance.sv =====
// Brightness level to panel luminance mapper, top level.
// Depends on lbl_pkg, lbl_core and lbl_mul.
//
// Input channel: in_valid / in_stall with brightness_level. Output channel:
// out_valid / out_stall with panel_luminance in mcd/m^2. A transfer takes
// place at a clock edge with valid high and stall low.
// Config: cfg_we writes cfg_data into register cfg_index (0 min, 1 max);
// write only while no computation is in flight.
// A level equal to the last one answered is dropped in the transfer cycle
// with no result. Zero, full-scale or higher, zero-minimum and max<=min
// levels go straight to the done state and from there to the output register.
// Other levels run the sequencer: 2 normalize walks, 2 x 30 squaring steps
// on the shared multiplier, 10 shift-add, 45 divide and 30 exp2 steps,
// and a serial right shift.
// One item is in work at a time; in_stall is high while it runs.
// The output register holds a result while out_stall is high; the next
// item may be taken meanwhile and waits at its end until the slot frees.
// Reset restores min 5000 and max 500000 and forgets the last level.
module log_brightness_to_luminance #(
	parameter int FULL_SCALE = lbl_pkg::DEF_FULL_SCALE,
	parameter int LUM_WIDTH  = lbl_pkg::DEF_LUM_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [lbl_pkg::LEVEL_W-1:0]   brightness_level,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [lbl_pkg::LUM_W-1:0]     panel_luminance,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [lbl_pkg::LUM_W-1:0]     cfg_data
);

	lbl_pkg::lbl_cfg_t                cfg_q;
	lbl_pkg::lbl_stat_t               stat;
	logic [lbl_pkg::LEVEL_W-1:0]      prev_level_q;
	logic                             prev_valid_q;
	logic                             busy_q;
	logic                             out_valid_q;
	logic [lbl_pkg::LUM_W-1:0]        out_data_q;
	logic [lbl_pkg::LUM_W-1:0]        core_result;
	logic                             in_xfer;
	logic                             start;
	logic                             take;

	assign in_stall  = busy_q;
	assign in_xfer   = in_valid && !busy_q;
	assign start     = in_xfer && !(prev_valid_q && brightness_level == prev_level_q);
	assign take      = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign panel_luminance = out_data_q;

	lbl_core #(
		.FULL_SCALE (FULL_SCALE),
		.LUM_WIDTH  (LUM_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.level  (brightness_level),
		.cfg    (cfg_q),
		.take   (take),
		.result (core_result),
		.stat   (stat)
	);

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lo <= lbl_pkg::MIN_LUM_RESET;
			cfg_q.hi <= lbl_pkg::MAX_LUM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lbl_pkg::REG_MIN_LUM: cfg_q.lo <= cfg_data;
				lbl_pkg::REG_MAX_LUM: cfg_q.hi <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// track last answered level and the busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q <= '0;
			prev_valid_q <= 1'b0;
			busy_q       <= 1'b0;
		end else begin
			if (start) begin
				prev_level_q <= brightness_level;
				prev_valid_q <= 1'b1;
				busy_q       <= 1'b1;
			end else if (stat.done && take) begin
				busy_q <= 1'b0;
			end
		end
	end

	// hold the result until the receiver takes the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.done && take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done && take) begin
			out_data_q <= core_result;
		end
	end

	// a new result only appears after work was started
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.done && take) |-> busy_q)
		else $error("result produced without an accepted item");

	// input side open only while the sequencer rests
	a_open_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> stat.idle)
		else $error("input open while sequencer busy");

	// a started item leaves the sequencer busy next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (busy_q && !stat.idle))
		else $error("started item did not enter the sequencer");

endmodule

// ===== tb/lbl_checker.sv =====
// Scoreboard for the brightness-to-luminance mapper: watches both channels and the
// register port, predicts each luminance in fixed point and compares it on transfer.
// Depends on lbl_pkg for widths, reset values and register indexes.
`timescale 1ns / 1ps

module lbl_checker #(
	parameter int FULL_SCALE = lbl_pkg::DEF_FULL_SCALE,
	parameter int LUM_WIDTH  = lbl_pkg::DEF_LUM_WIDTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [lbl_pkg::LEVEL_W-1:0] brightness_level,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [lbl_pkg::LUM_W-1:0]   panel_luminance,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [lbl_pkg::LUM_W-1:0]   cfg_data,
	output int                          mismatches,
	output int                          pending,
	output int                          level_count,
	output int                          lum_count
);

	localparam int FRAC_BITS = 30;

	logic [lbl_pkg::LUM_W-1:0]   min_lum;
	logic [lbl_pkg::LUM_W-1:0]   max_lum;
	logic [lbl_pkg::LEVEL_W-1:0] last_level;
	logic                        last_seen;
	logic [lbl_pkg::LUM_W-1:0]   lum_expected_q[$];

	assign pending = lum_expected_q.size();

	function automatic logic [63:0] int_sqrt(input logic [63:0] x);
		logic [63:0] root;
		logic [63:0] probe;
		root  = 64'd0;
		probe = 64'd1 << 62;
		for (int j = 0; j < 32; j++) begin
			if (x >= root + probe) begin
				x    = x - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	// log2 in Q.30: leading-one position, then fraction bits by squaring
	function automatic logic [63:0] log2_fixed(input logic [31:0] v);
		int          msb;
		logic [63:0] mant;
		logic [63:0] frac;
		msb  = 0;
		frac = 64'd0;
		for (int b = 0; b < 32; b++)
			if (v[b])
				msb = b;
		mant = 64'(v) << (31 - msb);
		for (int i = 0; i < FRAC_BITS; i++) begin
			mant = (mant * mant) >> 31;
			frac = frac << 1;
			if (mant >= (64'd1 << 32)) begin
				frac[0] = 1'b1;
				mant    = mant >> 1;
			end
		end
		return (64'(msb) << FRAC_BITS) | frac;
	endfunction

	// 2^t for a Q.30 fraction, product of successive square roots of two, Q1.31
	function automatic logic [63:0] exp2_fixed(input logic [63:0] t);
		logic [63:0] acc;
		logic [63:0] root;
		acc  = 64'h8000_0000;
		root = 64'd1 << 32;
		for (int i = 1; i <= FRAC_BITS; i++) begin
			root = int_sqrt(root << 31);
			if (t[FRAC_BITS-i])
				acc = (acc * root) >> 31;
		end
		return acc;
	endfunction

	function automatic logic [63:0] level_to_lum(input logic [lbl_pkg::LEVEL_W-1:0] level);
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] expo;
		logic [63:0] whole;
		logic [63:0] prod;
		logic [63:0] lum;
		lo = 64'(min_lum);
		hi = 64'(max_lum);
		if (level == 0)
			return lo;
		if (int'(level) >= FULL_SCALE)
			return hi;
		if (lo == 0)
			return 64'd0;
		if (hi <= lo)
			return hi;
		expo  = (log2_fixed(hi[31:0]) - log2_fixed(lo[31:0])) * 64'(level)
			/ 64'(FULL_SCALE);
		whole = expo >> FRAC_BITS;
		prod  = lo * exp2_fixed(expo & ((64'd1 << FRAC_BITS) - 1));
		lum   = (whole > 31) ? hi : (prod >> (31 - whole));
		if (lum < lo)
			lum = lo;
		if (lum > hi)
			lum = hi;
		return lum;
	endfunction

	task automatic report(input string what, input logic [lbl_pkg::LUM_W-1:0] got,
			input logic [lbl_pkg::LUM_W-1:0] want);
		$display("mismatch at %0t: %s, got %0d expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	// track registers, predict on input transfer, compare on output transfer
	always @(posedge clk or negedge arst_n) begin
		logic [63:0]               lum;
		logic [lbl_pkg::LUM_W-1:0] want;
		if (!arst_n) begin
			min_lum    <= lbl_pkg::MIN_LUM_RESET;
			max_lum    <= lbl_pkg::MAX_LUM_RESET;
			last_level <= '0;
			last_seen  <= 1'b0;
			lum_expected_q.delete();
			mismatches  <= 0;
			level_count <= 0;
			lum_count   <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == lbl_pkg::REG_MIN_LUM)
					min_lum <= cfg_data;
				else
					max_lum <= cfg_data;
			end
			if (in_valid && !in_stall) begin
				level_count <= level_count + 1;
				if (!(last_seen && brightness_level == last_level)) begin
					lum = level_to_lum(brightness_level);
					if (lum > (64'd1 << LUM_WIDTH) - 1)
						lum = (64'd1 << LUM_WIDTH) - 1;
					lum_expected_q.push_back(lum[lbl_pkg::LUM_W-1:0]);
					last_level <= brightness_level;
					last_seen  <= 1'b1;
				end
			end
			if (out_valid && !out_stall) begin
				lum_count <= lum_count + 1;
				if (lum_expected_q.size() == 0) begin
					report("luminance with none pending", panel_luminance, '0);
				end else begin
					want = lum_expected_q.pop_front();
					if (panel_luminance !== want)
						report("panel_luminance", panel_luminance, want);
				end
			end
		end
	end

endmodule

// ===== tb/testbench.sv =====
// Top of the brightness mapper testbench: clock, reset, level and register stimulus,
// receiver stalls, watchdog and verdict. Depends on lbl_pkg, lbl_checker and the block.
`timescale 1ns / 1ps

module testbench;

	localparam int IDLE_LIMIT  = 20000;
	localparam int DRAIN_WAIT  = 400;
	localparam int HOLD_CYCLES = 3000;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	logic [lbl_pkg::LEVEL_W-1:0] brightness_level;
	logic                        out_valid;
	logic                        out_stall;
	logic [lbl_pkg::LUM_W-1:0]   panel_luminance;
	logic                        cfg_we;
	logic                        cfg_index;
	logic [lbl_pkg::LUM_W-1:0]   cfg_data;
	int                          mismatches;
	int                          pending;
	int                          level_count;
	int                          lum_count;
	int                          settings_count;
	int                          idle_cycles;
	logic [lbl_pkg::LEVEL_W-1:0] prev_sent;
	bit                          hold_done;

	log_brightness_to_luminance DUT (.*);

	lbl_checker scoreboard (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// end the run when no transfer happens for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no transfer in %0d cycles", IDLE_LIMIT);
			$display("[log_brightness_to_luminance] ERROR");
			$finish;
		end
	end

	// receiver: stall in phases of random style, one long hold-off to back up the block
	initial begin
		int style;
		out_stall = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!hold_done && lum_count > 40) begin
				hold_done = 1'b1;
				@(posedge clk);
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			style = $urandom_range(0, 3);
			repeat ($urandom_range(5, 60)) begin
				@(posedge clk);
				case (style)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 2) == 0);
					2: out_stall <= 1'($urandom_range(0, 1));
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// offer one level and hold it until the block takes it
	task automatic send_level(input logic [lbl_pkg::LEVEL_W-1:0] level);
		in_valid         <= 1'b1;
		brightness_level <= level;
		prev_sent = level;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic pause(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// wait for the block to drain, then load both luminance limits
	task automatic set_limits(input logic [lbl_pkg::LUM_W-1:0] lo,
			input logic [lbl_pkg::LUM_W-1:0] hi);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= lbl_pkg::REG_MIN_LUM;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= lbl_pkg::REG_MAX_LUM;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_count++;
	endtask

	// mostly levels inside the curve, some repeats and some beyond full scale
	task automatic random_levels(input int count);
		int left;
		int pick;
		left = count;
		while (left > 0) begin
			repeat ($urandom_range(1, 8)) begin
				if (left > 0) begin
					pick = $urandom_range(0, 9);
					if (pick < 7)
						send_level(lbl_pkg::LEVEL_W'($urandom_range(0, 100)));
					else if (pick == 7)
						send_level(prev_sent);
					else
						send_level(lbl_pkg::LEVEL_W'($urandom_range(0, 1023)));
					left--;
				end
			end
			if ($urandom_range(0, 3) != 0)
				pause($urandom_range(0, 6));
		end
	endtask

	initial begin
		int drain;
		arst_n           = 1'b0;
		in_valid         = 1'b0;
		brightness_level = '0;
		cfg_we           = 1'b0;
		cfg_index        = lbl_pkg::REG_MIN_LUM;
		cfg_data         = '0;
		prev_sent        = '0;
		settings_count   = 1;
		idle_cycles      = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: ends of the range, repeats, beyond full scale, reset limits
		send_level(10'd0);
		send_level(10'd0);
		send_level(10'd100);
		send_level(10'd99);
		send_level(10'd1);
		send_level(10'd50);
		send_level(10'd1023);
		send_level(10'd1023);
		send_level(10'd101);
		send_level(10'd512);
		send_level(10'd341);
		send_level(10'd682);
		// zero minimum, then minimum above maximum, then equal limits
		set_limits(24'd0, 24'hFFFFFF);
		send_level(10'd0);
		send_level(10'd37);
		send_level(10'd100);
		set_limits(24'hFFFFFF, 24'd0);
		send_level(10'd0);
		send_level(10'd63);
		send_level(10'd1023);
		set_limits(24'd1000, 24'd1000);
		send_level(10'd42);
		send_level(10'd0);
		send_level(10'd100);

		// random phases over a spread of limit settings
		random_levels(200);
		set_limits(24'd1, 24'hFFFFFF);
		random_levels(160);
		set_limits(24'd0, 24'd500000);
		random_levels(120);
		set_limits(24'hFFFFFF, 24'hFFFFFF);
		random_levels(100);
		set_limits(24'd1, 24'd2);
		random_levels(140);
		set_limits(24'd200, 24'd100);
		random_levels(100);
		repeat (3) begin
			set_limits(lbl_pkg::LUM_W'($urandom_range(1, 5000)),
				lbl_pkg::LUM_W'($urandom_range(100000, 16777215)));
			random_levels(160);
		end
		in_valid <= 1'b0;

		// wait for outstanding results, then a little longer for stray output
		drain = 0;
		while (pending != 0 && drain < 50 * IDLE_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("covered %0d level transfers and %0d luminance results", level_count, lum_count);
		$display("across %0d limit settings, zero and full levels included", settings_count);
		if (mismatches == 0 && pending == 0) begin
			$display("[log_brightness_to_luminance] OK");
		end else begin
			$display("%0d mismatches, %0d results never arrived", mismatches, pending);
			$display("[log_brightness_to_luminance] ERROR");
		end
		$finish;
	end

endmodule
